>>> hdl/assert_macros.svh
// Assertion helpers shared by the RTL.
// Each macro takes a label, the clock, the reset, an antecedent and a consequent.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// Consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`endif

>>> hdl/abd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abd_pkg
// Types, memory-map constants and address wrap helpers for the bus decoder.
// ----------------------------------------------------------------------------
package abd_pkg;

  localparam int RAM_DEPTH        = 4096;
  localparam int ROM_BANK_DEPTH   = 16384;
  localparam int SPRITE_REG_COUNT = 16;

  localparam int RAM_WINDOW = 4096;
  localparam int ROM_WINDOW = 16384;

  localparam int RAM_AW = $clog2(RAM_DEPTH);
  localparam int ROM_AW = $clog2(2 * ROM_BANK_DEPTH);
  localparam int SPR_AW = $clog2(SPRITE_REG_COUNT);

  localparam int RAM_WRAP_STEPS = RAM_WINDOW / RAM_DEPTH;
  localparam int ROM_WRAP_STEPS = ROM_WINDOW / ROM_BANK_DEPTH;

  localparam logic [15:0] MIRROR_MASK  = 16'h7fff;
  localparam logic [15:0] RAM_BASE     = 16'h4000;
  localparam logic [15:0] IO_BASE      = 16'h5000;
  localparam logic [15:0] PORT_A_ADDR  = 16'h5000;
  localparam logic [15:0] PORT_B_ADDR  = 16'h5040;
  localparam logic [15:0] PORT_C_ADDR  = 16'h5080;
  localparam logic [15:0] PORT_D_ADDR  = 16'h50c0;
  localparam logic [15:0] IRQ_ADDR     = 16'h5000;
  localparam logic [15:0] FLIP_ADDR    = 16'h5003;
  localparam logic [15:0] SPR_BASE     = 16'h5060;
  localparam logic [15:0] SPR_END      = 16'h5070;
  localparam logic [15:0] EXT_ROM_BASE = 16'h8000;
  localparam logic [15:0] EXT_ROM_END  = 16'hc000;

  typedef enum logic [1:0] {
    FUNC_READ  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_LOAD  = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    SRC_FIXED = 2'd0,
    SRC_ROM   = 2'd1,
    SRC_RAM   = 2'd2
  } src_t;

  typedef struct packed {
    src_t              src;
    logic [7:0]        fixed_byte;
    logic [ROM_AW-1:0] rom_addr;
    logic              rom_we;
    logic [RAM_AW-1:0] ram_addr;
    logic              ram_we;
    logic              irq_we;
    logic              flip_we;
    logic              spr_we;
    logic [SPR_AW-1:0] spr_idx;
  } dec_t;

  // Wrap a 12-bit window offset into the RAM depth.
  function automatic logic [RAM_AW-1:0] ram_wrap(input logic [11:0] off);
    logic [11:0] v;
    v = off;
    for (int i = 0; i < RAM_WRAP_STEPS; i++) begin
      if (int'(v) >= RAM_DEPTH) v = v - 12'(RAM_DEPTH);
    end
    return RAM_AW'(v);
  endfunction

  // Combined ROM index from bank and 14-bit offset, offset wrapped to bank depth.
  function automatic logic [ROM_AW-1:0] rom_index(input logic bank, input logic [13:0] off);
    logic [13:0] v;
    v = off;
    for (int i = 0; i < ROM_WRAP_STEPS; i++) begin
      if (int'(v) >= ROM_BANK_DEPTH) v = v - 14'(ROM_BANK_DEPTH);
    end
    return bank ? ROM_AW'(ROM_BANK_DEPTH) + ROM_AW'(v) : ROM_AW'(v);
  endfunction

endpackage

>>> hdl/abd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abd_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module abd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

>>> hdl/abd_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abd_decode
// Address decode of one bus access: read source, memory strobes, register writes.
// ----------------------------------------------------------------------------
module abd_decode (
  input  abd_pkg::func_t func,
  input  logic [15:0]    address,
  input  logic [7:0]     port_a,
  input  logic [7:0]     port_b,
  input  logic [7:0]     port_c,
  input  logic [7:0]     port_d,
  input  logic           ext_rom,
  output abd_pkg::dec_t  dec
);
  import abd_pkg::*;

  logic [15:0] ra;
  logic [15:0] wa;

  assign ra = ext_rom ? address : (address & MIRROR_MASK);
  assign wa = address & MIRROR_MASK;

  always_comb begin
    dec            = '0;
    dec.src        = SRC_FIXED;
    dec.fixed_byte = 8'h00;
    dec.rom_addr   = rom_index(ra[15], ra[13:0]);
    dec.ram_addr   = ram_wrap(ra[11:0]);
    dec.spr_idx    = wa[SPR_AW-1:0];
    unique case (func)
      FUNC_READ: begin
        if (ra < RAM_BASE) dec.src = SRC_ROM;
        else if (ra < IO_BASE) dec.src = SRC_RAM;
        else if (ra == PORT_A_ADDR) dec.fixed_byte = port_a;
        else if (ra == PORT_B_ADDR) dec.fixed_byte = port_b;
        else if (ra == PORT_C_ADDR) dec.fixed_byte = port_c;
        else if (ra == PORT_D_ADDR) dec.fixed_byte = port_d;
        else if (ra >= EXT_ROM_BASE && ra < EXT_ROM_END) dec.src = SRC_ROM;
      end
      FUNC_WRITE: begin
        dec.ram_addr = ram_wrap(wa[11:0]);
        if (wa >= RAM_BASE && wa < IO_BASE) dec.ram_we = 1'b1;
        else if (wa == IRQ_ADDR) dec.irq_we = 1'b1;
        else if (wa == FLIP_ADDR) dec.flip_we = 1'b1;
        else if (wa >= SPR_BASE && wa < SPR_END) dec.spr_we = 1'b1;
      end
      FUNC_LOAD: begin
        dec.rom_addr = rom_index(address[14], address[13:0]);
        dec.rom_we   = 1'b1;
      end
      default: begin
        dec.src = SRC_FIXED;
      end
    endcase
  end

endmodule

>>> hdl/arcade_bus_address_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arcade_bus_address_decoder_top
// Memory-map decoder of an 8-bit CPU bus: ROM, work RAM, ports, control bits.
// ----------------------------------------------------------------------------
// One bus access is taken per clock while the output drains and no clearing pass
// runs: the transfer edge registers the decode together with the registered read
// of the program ROM or work RAM, and the output register loads when the output
// stage advances. Sustained rate is one access per cycle, set by the single read
// port of each memory. After reset the work RAM is zeroed by a clearing pass over
// all RAM_DEPTH addresses, one byte a cycle, during which s_tready stays low;
// configuration writes are taken at any time. Program ROM has no reset and must
// be loaded before it is read. A stalled output holds the pipeline; an input
// transfer is still taken while the decode stage is free.
`include "assert_macros.svh"

module arcade_bus_address_decoder_top (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // address[15:0], write_data[23:16], port_a[31:24],
                                 // port_b[39:32], port_c[47:40], port_d[55:48]
  input  logic [1:0]  s_tuser,   // func[1:0]
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // read_data[7:0], irq_enable[8], flip_screen[9], zero[15:10]
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data   // extended_rom_present
);
  import abd_pkg::*;

  logic [15:0] address;
  logic [7:0]  write_data;
  logic        accept;
  logic        advance;
  dec_t        dec;

  // configuration and architectural state
  logic        ext_rom;
  logic        irq_bit;
  logic        flip_bit;
  logic        irq_bit_next;
  logic        flip_bit_next;
  logic [7:0]  spr_pos [SPRITE_REG_COUNT];
  logic        spr_we;

  // work RAM clearing pass
  logic              clearing;
  logic [RAM_AW-1:0] clr_addr;
  logic              clr_last;

  // decode stage
  logic       s1_valid;
  src_t       s1_src;
  logic [7:0] s1_fixed;
  logic       s1_irq;
  logic       s1_flip;

  // output stage
  logic       m_valid;
  logic [7:0] m_read;
  logic       m_irq;
  logic       m_flip;

  logic [7:0]        rom_rdata;
  logic [7:0]        ram_rdata;
  logic              ram_we;
  logic [RAM_AW-1:0] ram_waddr;
  logic [7:0]        ram_wdata;

  assign address    = s_tdata[15:0];
  assign write_data = s_tdata[23:16];

  // Advance the decode stage when the output register is empty or being drained.
  assign advance  = !m_valid || m_tready;
  assign s_tready = !clearing && (!s1_valid || advance);
  assign accept   = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  abd_decode u_decode (
    .func    (func_t'(s_tuser)),
    .address (address),
    .port_a  (s_tdata[31:24]),
    .port_b  (s_tdata[39:32]),
    .port_c  (s_tdata[47:40]),
    .port_d  (s_tdata[55:48]),
    .ext_rom (ext_rom),
    .dec     (dec)
  );

  abd_ram #(.WIDTH(8), .DEPTH(2 * ROM_BANK_DEPTH)) u_rom (
    .clk   (clk),
    .we    (accept && dec.rom_we),
    .waddr (dec.rom_addr),
    .wdata (write_data),
    .re    (accept),
    .raddr (dec.rom_addr),
    .rdata (rom_rdata)
  );

  // Steal the write port for the clearing pass.
  assign ram_we    = clearing || (accept && dec.ram_we);
  assign ram_waddr = clearing ? clr_addr : dec.ram_addr;
  assign ram_wdata = clearing ? 8'h00 : write_data;
  assign clr_last  = (clr_addr == RAM_AW'(RAM_DEPTH - 1));

  abd_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (dec.ram_addr),
    .rdata (ram_rdata)
  );

  // Control bits as they stand after this access.
  assign irq_bit_next  = (accept && dec.irq_we) ? write_data[0] : irq_bit;
  assign flip_bit_next = (accept && dec.flip_we) ? write_data[0] : flip_bit;
  assign spr_we        = accept && dec.spr_we;

  always_ff @(posedge clk) begin
    if (rst) begin
      ext_rom  <= 1'b0;
      irq_bit  <= 1'b0;
      flip_bit <= 1'b0;
      clearing <= 1'b1;
      clr_addr <= '0;
      s1_valid <= 1'b0;
      m_valid  <= 1'b0;
      for (int i = 0; i < SPRITE_REG_COUNT; i++) spr_pos[i] <= 8'h00;
    end else begin
      if (cfg_valid && cfg_ready) ext_rom <= cfg_data;
      irq_bit  <= irq_bit_next;
      flip_bit <= flip_bit_next;
      if (spr_we) spr_pos[dec.spr_idx] <= write_data;

      if (clearing) begin
        clr_addr <= clr_addr + RAM_AW'(1);
        if (clr_last) clearing <= 1'b0;
      end

      if (accept) s1_valid <= 1'b1;
      else if (advance) s1_valid <= 1'b0;

      if (advance) m_valid <= s1_valid;
      else if (m_tready) m_valid <= 1'b0;
    end
  end

  // Payload of the decode stage: hold while stalled.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_src   <= dec.src;
      s1_fixed <= dec.fixed_byte;
      s1_irq   <= irq_bit_next;
      s1_flip  <= flip_bit_next;
    end
  end

  // Output register: select the read source.
  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      case (s1_src)
        SRC_ROM: m_read <= rom_rdata;
        SRC_RAM: m_read <= ram_rdata;
        default: m_read <= s1_fixed;
      endcase
      m_irq  <= s1_irq;
      m_flip <= s1_flip;
    end
  end

  assign m_tvalid = m_valid;
  assign m_tdata  = {6'b0, m_flip, m_irq, m_read};

  `ASSERT_SAME(a_no_accept_while_clearing, clk, rst, clearing, !s_tready)
  `ASSERT_NEXT(a_clear_ends_at_last, clk, rst, $fell(clearing), $past(clr_last, 2))
  `ASSERT_NEXT(a_decode_holds, clk, rst, s1_valid && !advance, s1_valid)
  `ASSERT_NEXT(a_irq_write, clk, rst, accept && dec.irq_we, irq_bit == $past(write_data[0]))
  `ASSERT_NEXT(a_sprite_write, clk, rst, spr_we, spr_pos[$past(dec.spr_idx)] == $past(write_data))

endmodule
